### rtl/core/calendar_clock_tick_core_macros.svh
// Assertion macros shared by the calendar clock tick core.
`ifndef CALENDAR_CLOCK_TICK_CORE_MACROS_SVH
`define CALENDAR_CLOCK_TICK_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CCT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("calendar clock tick core assertion failed");
`define CCT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("calendar clock tick core assertion failed");
`else
`define CCT_ASSERT(label, clk, rst, prop)
`define CCT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/core/cct_pkg.sv
// Types, constants and calendar functions of the calendar clock tick core.
`timescale 1ns / 1ps
package cct_pkg;

   localparam int TICKS_PER_SECOND_DEF = 1000;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   localparam logic [5:0]  SECOND_LIMIT = 6'd60;
   localparam logic [5:0]  MINUTE_LIMIT = 6'd60;
   localparam logic [4:0]  HOUR_LIMIT   = 5'd24;
   localparam logic [3:0]  MONTH_LAST   = 4'd12;
   localparam logic [4:0]  LEAP_FEB_LEN = 5'd29;
   localparam logic [4:0]  LONG_MONTH   = 5'd31;
   localparam logic [3:0]  FEBRUARY     = 4'd2;

   // Multiplying by the inverse of 25 modulo 2^16 maps exactly the multiples
   // of 25 onto the range 0 to 2621.
   localparam logic [15:0] INV25_MOD16 = 16'h5C29;
   localparam logic [15:0] DIV25_MAX   = 16'd2621;

   localparam logic [15:0] RESET_YEAR   = 16'd2026;
   localparam logic [3:0]  RESET_MONTH  = 4'd3;
   localparam logic [4:0]  RESET_DAY    = 5'd30;
   localparam logic [4:0]  RESET_HOUR   = 5'd15;
   localparam logic [5:0]  RESET_MINUTE = 6'd0;
   localparam logic [5:0]  RESET_SECOND = 6'd0;

   localparam logic [4:0] DAYS_IN_MONTH [0:11] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   function automatic logic is_leap(input logic [15:0] year);
      logic [15:0] prod;
      logic        div4;
      logic        div16;
      logic        div25;
      prod  = 16'(year * INV25_MOD16);
      div25 = (prod <= DIV25_MAX);
      div4  = (year[1:0] == 2'd0);
      div16 = (year[3:0] == 4'd0);
      return (div4 && !div25) || (div16 && div25);
   endfunction

   function automatic logic [4:0] month_length(input logic [15:0] year,
                                               input logic [3:0]  month);
      logic [4:0] len;
      if ((month == 4'd0) || (month > MONTH_LAST)) begin
         len = LONG_MONTH;
      end else if ((month == FEBRUARY) && is_leap(year)) begin
         len = LEAP_FEB_LEN;
      end else begin
         len = DAYS_IN_MONTH[month - 4'd1];
      end
      return len;
   endfunction

endpackage

### rtl/core/cct_second_carry.sv
// Advances a calendar by one second with minute, hour, day, month and year carries.
`timescale 1ns / 1ps
module cct_second_carry
   import cct_pkg::*;
(
   input  calendar_type cal,
   output calendar_type cal_next
);

   logic [6:0] second_inc;
   logic [6:0] minute_inc;
   logic [5:0] hour_inc;
   logic [5:0] day_inc;
   logic [4:0] month_inc;
   logic [4:0] days_this_month;

   assign second_inc      = {1'b0, cal.second} + 7'd1;
   assign minute_inc      = {1'b0, cal.minute} + 7'd1;
   assign hour_inc        = {1'b0, cal.hour} + 6'd1;
   assign day_inc         = {1'b0, cal.day} + 6'd1;
   assign month_inc       = {1'b0, cal.month} + 5'd1;
   assign days_this_month = month_length(cal.year, cal.month);

   always_comb begin
      cal_next = cal;
      if (second_inc < {1'b0, SECOND_LIMIT}) begin
         cal_next.second = second_inc[5:0];
      end else begin
         cal_next.second = 6'd0;
         if (minute_inc < {1'b0, MINUTE_LIMIT}) begin
            cal_next.minute = minute_inc[5:0];
         end else begin
            cal_next.minute = 6'd0;
            if (hour_inc < {1'b0, HOUR_LIMIT}) begin
               cal_next.hour = hour_inc[4:0];
            end else begin
               cal_next.hour = 5'd0;
               if (day_inc <= {1'b0, days_this_month}) begin
                  cal_next.day = day_inc[4:0];
               end else begin
                  cal_next.day = 5'd1;
                  if (month_inc <= {1'b0, MONTH_LAST}) begin
                     cal_next.month = month_inc[3:0];
                  end else begin
                     cal_next.month = 4'd1;
                     cal_next.year  = cal.year + 16'd1;
                  end
               end
            end
         end
      end
   end

endmodule

### rtl/core/calendar_clock_tick_core.sv
// Top level of the calendar clock tick core: input stage, clock state and result register.
//
// The req channel carries one beat per event. With req_tuser low the beat is
// a one-millisecond tick; with req_tuser high it loads the calendar from the
// date and time in req_tdata, leaving the tick count and sub-second phase as
// they are. Every TICKS_PER_SECOND ticks the calendar advances one second,
// carrying through month lengths and the Gregorian leap-year rule.
// Each req beat yields exactly one rsp beat: the calendar after the event,
// the free-running 32-bit tick count, and in rsp_tuser a strobe that is high
// when that tick advanced the calendar.
// A beat accepted on req is registered in the input stage, and its result is
// registered in the result register once that register is free, which raises
// rsp_tvalid. The carry logic is combinational, so one beat per cycle is
// sustained in both directions while the receiver keeps rsp_tready high.
// Synchronous reset empties both stages, clears the tick count and sub-second
// counter and sets the calendar to 2026-03-30 15:00:00.
// When the receiver holds rsp_tready low, the result stays in place, the input
// stage takes one more beat if it is empty, and then req_tready falls.
`timescale 1ns / 1ps
module calendar_clock_tick_core
   import cct_pkg::*;
#(
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // set_year, set_month, set_day, set_hour, set_minute, set_second, zero pad.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode.
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
   // tick_total, zero pad.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // second_strobe.
   output logic                  rsp_tuser
);

`include "calendar_clock_tick_core_macros.svh"

   localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
   localparam logic [SUB_W:0] SUB_LIMIT = (SUB_W + 1)'(TICKS_PER_SECOND);

   logic             s1_valid_ff;
   logic             s1_op_ff;
   calendar_type     s1_set_ff;
   logic             rsp_valid_ff;
   calendar_type     rsp_cal_ff;
   logic             rsp_strobe_ff;
   logic [31:0]      rsp_tick_ff;
   logic [31:0]      tick_ff;
   logic [SUB_W-1:0] sub_ff;
   calendar_type     cal_ff;

   logic [31:0]      tick_in;
   logic [SUB_W-1:0] sub_in;
   calendar_type     cal_in;
   logic             strobe_in;

   logic             out_free;
   logic             s1_move;
   logic [SUB_W:0]   sub_inc;
   logic             sub_roll;
   calendar_type     cal_adv;
   calendar_type     req_set;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign req_set.year   = req_tdata[15:0];
   assign req_set.month  = req_tdata[19:16];
   assign req_set.day    = req_tdata[24:20];
   assign req_set.hour   = req_tdata[29:25];
   assign req_set.minute = req_tdata[35:30];
   assign req_set.second = req_tdata[41:36];

   cct_second_carry u_second_carry (
      .cal      (cal_ff),
      .cal_next (cal_adv)
   );

   assign sub_inc  = {1'b0, sub_ff} + {{SUB_W{1'b0}}, 1'b1};
   assign sub_roll = (sub_inc >= SUB_LIMIT);

   always_comb begin
      tick_in   = tick_ff;
      sub_in    = sub_ff;
      cal_in    = cal_ff;
      strobe_in = 1'b0;
      case (s1_op_ff)
         OP_SET: begin
            cal_in = s1_set_ff;
         end
         OP_TICK: begin
            tick_in = tick_ff + 32'd1;
            if (sub_roll) begin
               sub_in    = '0;
               cal_in    = cal_adv;
               strobe_in = 1'b1;
            end else begin
               sub_in = sub_inc[SUB_W-1:0];
            end
         end
         default: begin
            cal_in = cal_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tick_ff       <= 32'd0;
         sub_ff        <= '0;
         cal_ff.year   <= RESET_YEAR;
         cal_ff.month  <= RESET_MONTH;
         cal_ff.day    <= RESET_DAY;
         cal_ff.hour   <= RESET_HOUR;
         cal_ff.minute <= RESET_MINUTE;
         cal_ff.second <= RESET_SECOND;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            tick_ff <= tick_in;
            sub_ff  <= sub_in;
            cal_ff  <= cal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff  <= req_tuser;
         s1_set_ff <= req_set;
      end
      if (s1_move) begin
         rsp_cal_ff    <= cal_in;
         rsp_strobe_ff <= strobe_in;
         rsp_tick_ff   <= tick_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_strobe_ff;
   assign rsp_tdata  = {6'd0, rsp_tick_ff, rsp_cal_ff.second, rsp_cal_ff.minute,
                        rsp_cal_ff.hour, rsp_cal_ff.day, rsp_cal_ff.month,
                        rsp_cal_ff.year};

   `CCT_ASSERT(a_sub_below_limit, clock, reset, ({1'b0, sub_ff} < SUB_LIMIT))
   `CCT_ASSERT(a_set_no_strobe, clock, reset, (s1_move && s1_op_ff) |=> !rsp_tuser)
   `CCT_ASSERT(a_tick_counts, clock, reset, (s1_move && !s1_op_ff) |=> (tick_ff == ($past(tick_ff) + 32'd1)))
   `CCT_ASSERT(a_set_keeps_tick, clock, reset, (s1_move && s1_op_ff) |=> ($stable(tick_ff) && $stable(sub_ff)))
   `CCT_ASSERT(a_stall_holds_stage, clock, reset, (rsp_tvalid && !rsp_tready) |-> !s1_move)

endmodule

### verif/calendar_tick_checker.sv
// Checker for the calendar clock tick core: predicts each result beat and compares it.
`timescale 1ns / 1ps
module calendar_tick_checker
   import cct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct {
      calendar_type wall;
      logic         strobe;
      logic [31:0]  ticks;
   } clock_reading_type;

   clock_reading_type pending_readings[$];
   calendar_type      wall;
   logic [31:0]       ms_count;
   int unsigned       ms_phase;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in(int unsigned y, int unsigned m);
      if ((m < 1) || (m > MONTH_LAST)) begin
         return LONG_MONTH;
      end
      if ((m == FEBRUARY) && leap_year(y)) begin
         return LEAP_FEB_LEN;
      end
      return DAYS_IN_MONTH[m - 1];
   endfunction

   // Each stage compares at full precision, so out-of-range values carry too.
   function automatic void bump_second();
      int unsigned v;
      v = wall.second + 1;
      if (v < SECOND_LIMIT) begin
         wall.second = 6'(v);
         return;
      end
      wall.second = '0;
      v = wall.minute + 1;
      if (v < MINUTE_LIMIT) begin
         wall.minute = 6'(v);
         return;
      end
      wall.minute = '0;
      v = wall.hour + 1;
      if (v < HOUR_LIMIT) begin
         wall.hour = 5'(v);
         return;
      end
      wall.hour = '0;
      v = wall.day + 1;
      if (v <= days_in(wall.year, wall.month)) begin
         wall.day = 5'(v);
         return;
      end
      wall.day = 5'd1;
      v = wall.month + 1;
      if (v <= MONTH_LAST) begin
         wall.month = 4'(v);
         return;
      end
      wall.month = 4'd1;
      wall.year  = wall.year + 16'd1;
   endfunction

   function automatic clock_reading_type clock_after_beat(logic op,
                                                          logic [REQ_DATA_W-1:0] data);
      clock_reading_type r;
      r.strobe = 1'b0;
      if (op == OP_SET) begin
         wall.year   = data[15:0];
         wall.month  = data[19:16];
         wall.day    = data[24:20];
         wall.hour   = data[29:25];
         wall.minute = data[35:30];
         wall.second = data[41:36];
      end else begin
         ms_count = ms_count + 32'd1;
         ms_phase = (ms_phase + 1) % 1024;
         if (ms_phase >= TICKS_PER_SECOND_DEF) begin
            ms_phase = 0;
            bump_second();
            r.strobe = 1'b1;
         end
      end
      r.wall  = wall;
      r.ticks = ms_count;
      return r;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      clock_reading_type want;
      if (reset) begin
         ms_count = '0;
         ms_phase = 0;
         wall = '{RESET_YEAR, RESET_MONTH, RESET_DAY, RESET_HOUR, RESET_MINUTE,
                  RESET_SECOND};
         pending_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_readings.size() == 0) begin
               $error("A result beat arrived with no reading pending.");
               mismatches++;
            end else begin
               want = pending_readings.pop_front();
               check_field("cur_year", want.wall.year, rsp_tdata[15:0]);
               check_field("cur_month", want.wall.month, rsp_tdata[19:16]);
               check_field("cur_day", want.wall.day, rsp_tdata[24:20]);
               check_field("cur_hour", want.wall.hour, rsp_tdata[29:25]);
               check_field("cur_minute", want.wall.minute, rsp_tdata[35:30]);
               check_field("cur_second", want.wall.second, rsp_tdata[41:36]);
               check_field("second_strobe", want.strobe, rsp_tuser);
               check_field("tick_total", want.ticks, rsp_tdata[73:42]);
            end
         end
         if (req_tvalid && req_tready) begin
            pending_readings.push_back(clock_after_beat(req_tuser, req_tdata));
         end
      end
      outstanding = pending_readings.size();
   end

endmodule

### verif/tb.sv
// Testbench top for the calendar clock tick core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
   import cct_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_BEATS   = 600;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_HELD_OFF
   } ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int             mismatch_count;
   int             outstanding;
   int unsigned    ticks_sent = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             stretch_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   calendar_clock_tick_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   calendar_tick_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatch_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (stretch_left == 0) begin
         ready_mode   <= ready_mode_type'($urandom_range(0, 3));
         stretch_left <= $urandom_range(5, 60);
      end else begin
         stretch_left <= stretch_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_SPARSE:   rsp_tready <= (stretch_left % 8 == 0);
         default:        rsp_tready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL calendar_clock_tick_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_setting(calendar_type c);
      return {6'd0, c.second, c.minute, c.hour, c.day, c.month, c.year};
   endfunction

   function automatic calendar_type random_setting();
      calendar_type c;
      c.year   = 16'($urandom);
      c.month  = 4'($urandom);
      c.day    = 5'($urandom);
      c.hour   = 5'($urandom);
      c.minute = 6'($urandom);
      c.second = 6'($urandom);
      return c;
   endfunction

   // A date and time that sits on or near a rollover at several levels.
   function automatic calendar_type edge_setting();
      calendar_type c;
      case ($urandom_range(0, 4))
         0:       c.year = 16'($urandom_range(0, 163) * 400);
         1:       c.year = 16'($urandom_range(0, 655) * 100);
         2:       c.year = 16'($urandom_range(0, 16383) * 4);
         3:       c.year = 16'hFFFF;
         default: c.year = 16'($urandom);
      endcase
      c.month  = ($urandom_range(0, 7) == 0) ? 4'($urandom) :
                 ($urandom_range(0, 2) == 0) ? MONTH_LAST : 4'($urandom_range(1, 12));
      c.day    = ($urandom_range(0, 7) == 0) ? 5'($urandom) :
                 5'(28 + $urandom_range(0, 3));
      c.hour   = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'd23;
      c.minute = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd59;
      c.second = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd59;
      return c;
   endfunction

   task automatic send_beat(logic op, logic [REQ_DATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (op == OP_TICK) begin
         ticks_sent++;
      end
   endtask

   task automatic send_tick();
      send_beat(OP_TICK, pack_setting(random_setting()));
   endtask

   task automatic send_setting(calendar_type c);
      send_beat(OP_SET, pack_setting(c));
   endtask

   // Ticks up to the last millisecond of a second, loads the setting, then ticks over.
   task automatic land_on_second(calendar_type c);
      while (ticks_sent % TICKS_PER_SECOND_DEF != TICKS_PER_SECOND_DEF - 1) begin
         if ($urandom_range(0, 199) == 0) begin
            send_setting(random_setting());
         end else begin
            send_tick();
         end
      end
      send_setting(c);
      repeat ($urandom_range(1, 4)) send_tick();
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
      burst_left = 0;
   endtask

   calendar_type boundaries [15];

   initial begin
      boundaries = '{
         '{16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
         '{16'd2024, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59},
         '{16'd2024, 4'd2,  5'd29, 5'd23, 6'd59, 6'd59},
         '{16'd2023, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59},
         '{16'd1900, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59},
         '{16'd2000, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59},
         '{16'd2026, 4'd4,  5'd30, 5'd23, 6'd59, 6'd59},
         '{16'd2026, 4'd1,  5'd31, 5'd23, 6'd59, 6'd59},
         '{16'd2026, 4'd0,  5'd31, 5'd23, 6'd59, 6'd59},
         '{16'd2026, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59},
         '{16'd2026, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63},
         '{16'd2026, 4'd6,  5'd30, 5'd23, 6'd59, 6'd58},
         '{16'd2026, 4'd6,  5'd30, 5'd23, 6'd58, 6'd59},
         '{16'd2026, 4'd6,  5'd31, 5'd23, 6'd59, 6'd59},
         '{16'd2026, 4'd2,  5'd0,  5'd23, 6'd59, 6'd59}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_tick();
      send_setting('{16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0});
      send_tick();
      send_setting('{16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59});
      send_tick();
      send_setting('{16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F});
      send_tick();
      send_setting('{16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0});
      send_tick();
      send_setting('{16'd2024, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30});
      send_setting('{16'd2000, 4'd2, 5'd28, 5'd1, 6'd2, 6'd3});
      send_tick();
      send_tick();
      send_setting('{16'h5555, 4'hA, 5'h15, 5'h0A, 6'h2A, 6'h15});
      send_tick();
      wait_until_drained();

      // A full second of ticks is needed per rollover, so one boundary is visited.
      land_on_second(boundaries[$urandom_range(0, $size(boundaries) - 1)]);

      repeat (RANDOM_BEATS) begin
         if ($urandom_range(0, 9) == 0) begin
            send_setting(($urandom_range(0, 1) == 0) ? random_setting() : edge_setting());
         end else begin
            send_tick();
         end
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if ((mismatch_count == 0) && (outstanding == 0)) begin
         $display("PASS calendar_clock_tick_core");
      end else begin
         $display("FAIL calendar_clock_tick_core");
      end
      $finish;
   end

endmodule
